[rtl/kat_pkg.sv]
// Shared types and constants for the keep-alive timeout table.
`timescale 1ns / 1ps

package kat_pkg;

    localparam int SLOT_W   = 6;
    localparam int KA_W     = 16;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int KASUM_W  = 17;
    localparam int FUNC_W   = 2;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REFRESH = 2'd0,
        FUNC_REMOVE  = 2'd1,
        FUNC_TICK    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REF_CHK,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_END
    } state_t;

endpackage

[rtl/keepalive_timeout_table.sv]
// Keep-alive timeout table: per-client deadlines with a serial expiry scan.
//
// Input transfers on s_* carry one command each: refresh (set a client's
// deadline to now plus 1.5 times its keep-alive, rounded up), remove, or tick.
// Refresh and remove take effect without any output; s_tready drops for one
// cycle after a valid refresh while the last-refresh time is read and checked.
// A tick with a new time scans all NUM_CLIENTS slots in ascending order, each
// slot read from the expiry memory and then compared, with s_tready low
// throughout. Each expired client gives one m_* transfer; m_tlast marks the
// final drop of the tick. A drop is held in a pending register until the next
// drop or the scan end, so its last flag is known, then moved to the output
// register. When m_tready is low the scan pauses on the next hit until the
// output register frees up; nothing is lost. Reset clears all monitored flags,
// the refresh-valid bits, the counters and the last tick time; the expiry
// memory is not cleared.
`timescale 1ns / 1ps

module keepalive_timeout_table #(
    parameter int NUM_CLIENTS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // client_slot[5:0], keep_alive_secs[21:6], time_now[53:22]
    input  logic [kat_pkg::S_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [kat_pkg::FUNC_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // drop_client[5:0], monitored_count[12:6], dropped_total[44:13]
    output logic [kat_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import kat_pkg::*;

    localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CLIENTS - 1);

    state_t state_reg, state_next;

    logic [NUM_CLIENTS-1:0] flag_reg, flag_next;
    logic [NUM_CLIENTS-1:0] lr_valid_reg, lr_valid_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [TIME_W-1:0]      total_reg, total_next;
    logic [TIME_W-1:0]      tick_reg, tick_next;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [KASUM_W-1:0] kasum_reg, kasum_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]  pend_slot_reg, pend_slot_next;
    logic [COUNT_W-1:0] pend_count_reg, pend_count_next;
    logic [TIME_W-1:0]  pend_total_reg, pend_total_next;

    logic               out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic               out_last_reg, out_last_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic [TIME_W-1:0]  out_total_reg, out_total_next;

    // expiry and last-refresh memories
    logic [TIME_W-1:0] exp_mem [NUM_CLIENTS];
    logic [TIME_W-1:0] lr_mem  [NUM_CLIENTS];
    logic [TIME_W-1:0] exp_rdata_reg, lr_rdata_reg;
    logic              rd_en, wr_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] exp_wdata;

    logic              accept;
    func_t             s_func;
    logic [SLOT_W-1:0] s_slot;
    logic [KA_W-1:0]   s_ka;
    logic [TIME_W-1:0] s_now;
    logic              s_slot_ok;
    logic [IDX_W-1:0]  s_idx;
    logic              out_free;
    logic              hit;
    logic [TIME_W-1:0] lr_val;

    assign s_func    = func_t'(s_tuser);
    assign s_slot    = s_tdata[5:0];
    assign s_ka      = s_tdata[21:6];
    assign s_now     = s_tdata[53:22];
    assign s_slot_ok = {1'b0, s_slot} < COUNT_W'(NUM_CLIENTS);
    assign s_idx     = s_slot[IDX_W-1:0];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign hit       = flag_reg[idx_reg] && (exp_rdata_reg <= now_reg);
    assign lr_val    = lr_valid_reg[idx_reg] ? lr_rdata_reg : '0;
    assign exp_wdata = now_reg + {{(TIME_W-KASUM_W){1'b0}}, kasum_reg};

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_total_reg, out_count_reg, out_slot_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            flag_reg       <= '0;
            lr_valid_reg   <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            tick_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            flag_reg       <= flag_next;
            lr_valid_reg   <= lr_valid_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            tick_reg       <= tick_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        now_reg        <= now_next;
        kasum_reg      <= kasum_next;
        pend_slot_reg  <= pend_slot_next;
        pend_count_reg <= pend_count_next;
        pend_total_reg <= pend_total_next;
        out_slot_reg   <= out_slot_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
        out_total_reg  <= out_total_next;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            exp_rdata_reg <= exp_mem[rd_addr];
            lr_rdata_reg  <= lr_mem[rd_addr];
        end
        if (wr_en) begin
            exp_mem[idx_reg] <= exp_wdata;
            lr_mem[idx_reg]  <= now_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        flag_next       = flag_reg;
        lr_valid_next   = lr_valid_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        tick_next       = tick_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        kasum_next      = kasum_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_count_next = pend_count_reg;
        pend_total_next = pend_total_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        out_total_next  = out_total_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                rd_addr = s_idx;
                if (accept) begin
                    idx_next   = s_idx;
                    now_next   = s_now;
                    kasum_next = {1'b0, s_ka} + {2'b00, s_ka[KA_W-1:1]}
                               + {{(KASUM_W-1){1'b0}}, s_ka[0]};
                    case (s_func)
                        FUNC_REFRESH: begin
                            if (s_slot_ok && s_ka != '0) begin
                                rd_en      = 1'b1;
                                state_next = ST_REF_CHK;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (s_slot_ok && s_ka != '0 && flag_reg[s_idx]) begin
                                flag_next[s_idx] = 1'b0;
                                count_next       = count_reg - 7'd1;
                            end
                        end
                        FUNC_TICK: begin
                            if (s_now != tick_reg) begin
                                idx_next   = '0;
                                state_next = ST_SCAN_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_REF_CHK: begin
                if (lr_val != now_reg) begin
                    wr_en                  = 1'b1;
                    lr_valid_next[idx_reg] = 1'b1;
                    if (!flag_reg[idx_reg]) begin
                        flag_next[idx_reg] = 1'b1;
                        count_next         = count_reg + 7'd1;
                    end
                end
                state_next = ST_IDLE;
            end
            ST_SCAN_RD: begin
                rd_en      = 1'b1;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                // stall only when a held drop must move out and output is busy
                if (!(hit && pend_valid_reg && !out_free)) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_slot_next  = pend_slot_reg;
                            out_last_next  = 1'b0;
                            out_count_next = pend_count_reg;
                            out_total_next = pend_total_reg;
                        end
                        flag_next[idx_reg] = 1'b0;
                        count_next         = count_reg - 7'd1;
                        total_next         = total_reg + 32'd1;
                        pend_valid_next    = 1'b1;
                        pend_slot_next     = SLOT_W'(idx_reg);
                        pend_count_next    = count_reg - 7'd1;
                        pend_total_next    = total_reg + 32'd1;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_SCAN_END;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_END: begin
                if (!pend_valid_reg) begin
                    tick_next  = now_reg;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = pend_slot_reg;
                    out_last_next   = 1'b1;
                    out_count_next  = pend_count_reg;
                    out_total_next  = pend_total_reg;
                    pend_valid_next = 1'b0;
                    tick_next       = now_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the keep-alive timeout table.
`timescale 1ns / 1ps

module tb_top;
    import kat_pkg::*;

    localparam int NUM_CMDS    = 210;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 300;
    localparam int WDOG_LIMIT  = 4000;

    typedef struct packed {
        func_t             op;
        logic [SLOT_W-1:0] slot;
        logic [KA_W-1:0]   ka;
        logic [TIME_W-1:0] now;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               last;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  total;
    } drop_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    keepalive_timeout_table #(.NUM_CLIENTS(64)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predicted table state
    logic               watched   [64];
    logic [TIME_W-1:0]  deadline  [64];
    logic [TIME_W-1:0]  refreshed [64];
    logic [COUNT_W-1:0] watched_cnt;
    logic [TIME_W-1:0]  drop_total;
    logic [TIME_W-1:0]  prev_tick;

    cmd_t  cmd_q[$];
    drop_t drops_due[$];
    int    mismatches  = 0;
    int    rx_count    = 0;
    int    idle_cycles = 0;
    int    tx_sent     = 0;
    int    tx_gap      = 0;
    int    rx_stall    = 0;
    logic  s_took      = 1'b0;
    logic  m_took      = 1'b0;
    logic  hold_done   = 1'b0;
    cmd_t  cur_cmd;
    int    rx_wait;

    // idle-free stretches alternate with random waits
    function automatic int draw_wait(input int n);
        return ((n % 48) < 16) ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic add_cmd(input func_t op, input logic [SLOT_W-1:0] slot,
                           input logic [KA_W-1:0] ka, input logic [TIME_W-1:0] now);
        cmd_t c;
        c.op   = op;
        c.slot = slot;
        c.ka   = ka;
        c.now  = now;
        cmd_q.push_back(c);
    endtask

    task automatic apply_command(input func_t op, input logic [SLOT_W-1:0] slot,
                                 input logic [KA_W-1:0] ka, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] k;
        int                final_hit;
        drop_t             d;
        k = TIME_W'(ka);
        final_hit = -1;
        case (op)
            FUNC_REFRESH: begin
                if (ka != 0 && refreshed[slot] != now) begin
                    if (!watched[slot]) begin
                        watched[slot] = 1'b1;
                        watched_cnt   = watched_cnt + 1'b1;
                    end
                    deadline[slot]  = now + k + ((k + 1) >> 1);
                    refreshed[slot] = now;
                end
            end
            FUNC_REMOVE: begin
                if (ka != 0 && watched[slot]) begin
                    watched[slot] = 1'b0;
                    watched_cnt   = watched_cnt - 1'b1;
                end
            end
            FUNC_TICK: begin
                if (now != prev_tick) begin
                    for (int s = 0; s < 64; s++)
                        if (watched[s] && deadline[s] <= now)
                            final_hit = s;
                    for (int s = 0; s < 64; s++) begin
                        if (watched[s] && deadline[s] <= now) begin
                            watched[s]  = 1'b0;
                            watched_cnt = watched_cnt - 1'b1;
                            drop_total  = drop_total + 1;
                            d.slot  = SLOT_W'(s);
                            d.last  = (s == final_hit);
                            d.count = watched_cnt;
                            d.total = drop_total;
                            drops_due.push_back(d);
                        end
                    end
                    prev_tick = now;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_drop();
        drop_t d;
        if (drops_due.size() == 0) begin
            $error("unexpected drop transfer: drop_client %0d", m_tdata[5:0]);
            mismatches++;
        end else begin
            d = drops_due.pop_front();
            if (m_tdata[5:0] !== d.slot) begin
                $error("drop_client: expected %0d, got %0d", d.slot, m_tdata[5:0]);
                mismatches++;
            end
            if (m_tlast !== d.last) begin
                $error("last_drop: expected %0d, got %0d", d.last, m_tlast);
                mismatches++;
            end
            if (m_tdata[12:6] !== d.count) begin
                $error("monitored_count: expected %0d, got %0d", d.count, m_tdata[12:6]);
                mismatches++;
            end
            if (m_tdata[44:13] !== d.total) begin
                $error("dropped_total: expected %0d, got %0d", d.total, m_tdata[44:13]);
                mismatches++;
            end
        end
    endtask

    task automatic gen_commands();
        logic [TIME_W-1:0] clk_s;
        logic [TIME_W-1:0] tick_at;
        logic [KA_W-1:0]   ka;
        int                n;
        int                p;
        int                r;

        // directed: reset corners, same-second refresh, removes, wrapped deadlines
        add_cmd(FUNC_TICK,    6'd0,  16'd0,     32'd0);
        add_cmd(FUNC_REFRESH, 6'd0,  16'd5,     32'd0);
        add_cmd(FUNC_REFRESH, 6'd0,  16'd1,     32'd10);
        add_cmd(FUNC_REFRESH, 6'd63, 16'hFFFF,  32'd20);
        add_cmd(FUNC_REFRESH, 6'd1,  16'd0,     32'd10);
        add_cmd(FUNC_REFRESH, 6'd0,  16'd3,     32'd10);
        add_cmd(FUNC_REFRESH, 6'd2,  16'd2,     32'd11);
        add_cmd(FUNC_REFRESH, 6'd3,  16'd4,     32'd11);
        add_cmd(FUNC_REMOVE,  6'd5,  16'd1,     32'd11);
        add_cmd(FUNC_REMOVE,  6'd2,  16'd0,     32'd11);
        add_cmd(FUNC_REMOVE,  6'd3,  16'hFFFF,  32'd11);
        add_cmd(FUNC_NONE,    6'd3,  16'd7,     32'd12);
        add_cmd(FUNC_TICK,    6'd0,  16'd0,     32'd12);
        add_cmd(FUNC_TICK,    6'd0,  16'd0,     32'd12);
        add_cmd(FUNC_TICK,    6'd0,  16'd0,     32'd14);
        add_cmd(FUNC_REFRESH, 6'd63, 16'd4,     32'hFFFF_FFFE);
        add_cmd(FUNC_REFRESH, 6'd10, 16'hFFFF,  32'hFFFF_FFFF);
        add_cmd(FUNC_REFRESH, 6'd11, 16'd1,     32'd100);
        add_cmd(FUNC_TICK,    6'd0,  16'd0,     32'd50);
        add_cmd(FUNC_TICK,    6'd0,  16'd0,     32'd5);
        add_cmd(FUNC_TICK,    6'd63, 16'hFFFF,  32'hFFFF_FFFF);
        add_cmd(FUNC_REMOVE,  6'd0,  16'd1,     32'hFFFF_FFFF);
        tick_at = 32'hFFFF_FFFF;

        // every slot at once, then one tick that expires all of them
        clk_s = $urandom;
        for (int s = 0; s < 64; s++)
            add_cmd(FUNC_REFRESH, SLOT_W'(s), KA_W'($urandom_range(1, 3)), clk_s);
        clk_s   = clk_s + $urandom_range(5, 8);
        tick_at = clk_s;
        add_cmd(FUNC_TICK, SLOT_W'($urandom), KA_W'($urandom), tick_at);

        while (cmd_q.size() < NUM_CMDS) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                p = $urandom_range(0, 9);
                if (p < 6) begin
                    ka = ($urandom_range(0, 7) == 0) ? KA_W'($urandom)
                                                     : KA_W'($urandom_range(1, 6));
                    add_cmd(FUNC_REFRESH, SLOT_W'($urandom), ka, clk_s);
                end else if (p < 8) begin
                    add_cmd(FUNC_REMOVE, SLOT_W'($urandom),
                            KA_W'($urandom_range(1, 65535)), clk_s);
                end else begin
                    r = $urandom_range(0, 2);
                    if (r == 0)
                        add_cmd(FUNC_NONE, SLOT_W'($urandom), KA_W'($urandom), $urandom);
                    else
                        add_cmd(r == 1 ? FUNC_REFRESH : FUNC_REMOVE, SLOT_W'($urandom),
                                16'd0, clk_s);
                end
                if ($urandom_range(0, 2) == 0)
                    clk_s = clk_s + 1;
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                add_cmd(FUNC_TICK, SLOT_W'($urandom), KA_W'($urandom), tick_at);
            end else if (r == 1) begin
                tick_at = clk_s - $urandom_range(1, 20);
                add_cmd(FUNC_TICK, SLOT_W'($urandom), KA_W'($urandom), tick_at);
            end else begin
                clk_s   = clk_s + $urandom_range(1, 6);
                tick_at = clk_s;
                add_cmd(FUNC_TICK, SLOT_W'($urandom), KA_W'($urandom), tick_at);
            end
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_took)) begin
            if (tx_gap != 0) begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (cmd_q.size() != 0) begin
                cur_cmd  = cmd_q.pop_front();
                s_tuser  <= cur_cmd.op;
                s_tdata  <= {2'b00, cur_cmd.now, cur_cmd.ka, cur_cmd.slot};
                s_tvalid <= 1'b1;
                tx_gap   <= draw_wait(tx_sent);
                tx_sent  <= tx_sent + 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off once drops are flowing
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_took && !hold_done && rx_count >= 8) begin
                hold_done <= 1'b1;
                m_tready  <= 1'b0;
                rx_stall  <= LONG_HOLD - 1;
            end else if (m_took) begin
                rx_wait = draw_wait(rx_count);
                m_tready <= (rx_wait == 0);
                rx_stall <= (rx_wait == 0) ? 0 : rx_wait - 1;
            end else if (rx_stall != 0) begin
                m_tready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor and predictor
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took      <= 1'b0;
            m_took      <= 1'b0;
            idle_cycles <= 0;
        end else begin
            s_took <= s_tvalid && s_tready;
            m_took <= m_tvalid && m_tready;
            if (m_tvalid && m_tready) begin
                check_drop();
                rx_count++;
            end
            if (s_tvalid && s_tready)
                apply_command(func_t'(s_tuser), s_tdata[5:0], s_tdata[21:6], s_tdata[53:22]);
            idle_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0
                                                                              : idle_cycles + 1;
        end
    end

    initial begin
        for (int s = 0; s < 64; s++) begin
            watched[s]   = 1'b0;
            deadline[s]  = '0;
            refreshed[s] = '0;
        end
        watched_cnt = '0;
        drop_total  = '0;
        prev_tick   = '0;
        gen_commands();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        fork
            begin
                while (cmd_q.size() != 0 || s_tvalid)
                    @(posedge aclk);
                while (drops_due.size() != 0)
                    @(posedge aclk);
                repeat (TAIL_CYCLES) @(posedge aclk);
                if (mismatches == 0 && drops_due.size() == 0)
                    $display("PASS keepalive_timeout_table");
                else
                    $display("FAIL keepalive_timeout_table");
                $finish;
            end
            begin
                while (idle_cycles < WDOG_LIMIT)
                    @(posedge aclk);
                $display("FAIL keepalive_timeout_table");
                $finish;
            end
        join
    end

endmodule

[filelist.f]
rtl/kat_pkg.sv
rtl/keepalive_timeout_table.sv
tb/tb_top.sv
